// ===== rtl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies; imported by sida_ctrl, sida_dp and signed_int_to_decimal_ascii.
package sida_pkg;

    // Default width of the signed input value
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // ASCII codes that the converter emits
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new value, clear counters
        logic step;        // one shift-add-3 conversion step
        logic skip;        // drop a leading zero digit
        logic emit_sign;   // present '-' on the output
        logic emit_digit;  // present the top digit and drop it
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic conv_done;   // all magnitude bits shifted into the BCD register
        logic top_zero;    // top remaining BCD digit is zero
        logic one_left;    // only one digit remains to be emitted
        logic negative;    // captured value was negative
    } t_dp_sts;

endpackage

// ===== rtl/sida_ctrl.sv =====
// Sequencing state machine for the decimal ASCII converter.
// Depends on sida_pkg (command and status structs).
module sida_ctrl
    import sida_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = ST_SKIP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_SKIP: begin
                // strip leading zeros, always keeping the units digit
                if (i_sts.top_zero && !i_sts.one_left) begin
                    o_cmd.skip = 1'b1;
                end else if (i_sts.negative) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_sts.one_left) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sida_dp.sv =====
// Datapath: magnitude capture, shift-add-3 binary to BCD, character output register.
// Depends on sida_pkg (structs, ASCII constants).
module sida_dp
    import sida_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    output logic                          o_strobe,
    output logic [6:0]                    o_ascii_char,
    output logic                          o_last_char
);

    // decimal digits of the largest VALUE_WIDTH-bit unsigned value (1233/4096 ~ log10 2)
    localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BW   = NDIG * 4;
    localparam int CW   = $clog2(VALUE_WIDTH + 1);
    localparam int DW   = $clog2(NDIG + 1);

    logic [VALUE_WIDTH-1:0] r_shift;
    logic [BW-1:0]          r_bcd;
    logic [CW-1:0]          r_bit_cnt;
    logic [DW-1:0]          r_dig_cnt;
    logic                   r_neg;
    logic                   r_strobe;
    logic [6:0]             r_char;
    logic                   r_last;

    logic [VALUE_WIDTH-1:0] n_mag;
    logic [BW-1:0]          n_adj;
    logic [3:0]             top_digit;

    // magnitude: two's complement negate, most negative value fits unsigned
    always_comb begin
        if (i_value[VALUE_WIDTH-1]) begin
            n_mag = ~$unsigned(i_value) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
        end else begin
            n_mag = $unsigned(i_value);
        end
    end

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign top_digit = r_bcd[BW-1 -: 4];

    // Conversion registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
        end else if (i_cmd.load) begin
            r_shift   <= n_mag;
            r_bcd     <= '0;
            r_neg     <= i_value[VALUE_WIDTH-1];
            r_bit_cnt <= '0;
            r_dig_cnt <= DW'(NDIG);
        end else if (i_cmd.step) begin
            {r_bcd, r_shift} <= {n_adj[BW-2:0], r_shift, 1'b0};
            r_bit_cnt        <= r_bit_cnt + 1'b1;
        end else if (i_cmd.skip || i_cmd.emit_digit) begin
            r_bcd     <= {r_bcd[BW-5:0], 4'd0};
            r_dig_cnt <= r_dig_cnt - 1'b1;
        end
    end

    // Output register: one character per strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_sign | i_cmd.emit_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= CHAR_ZERO + {3'd0, top_digit};
            r_last <= (r_dig_cnt == DW'(1));
        end
    end

    assign o_sts.conv_done = (r_bit_cnt == CW'(VALUE_WIDTH));
    assign o_sts.top_zero  = (top_digit == 4'd0);
    assign o_sts.one_left  = (r_dig_cnt == DW'(1));
    assign o_sts.negative  = r_neg;

    assign o_strobe     = r_strobe;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on sida_pkg, sida_ctrl and sida_dp.

// A value is taken when start is high while busy is low. The block then
// emits the decimal text one character per o_strobe pulse: '-' first for a
// negative value, then the digits most significant first with no leading
// zeros, o_last_char marking the final one. Each character is present for
// a single cycle and must be captured then; the block cannot be stalled.
// One item passes through acceptance, VALUE_WIDTH shift-add-3 steps, a check
// that the bit count is complete, the dropping of leading zeros, a sign for
// a negative value and then the digits. Dropped zeros and digits always
// add up to the BCD register's digit count, so the time that an item takes
// depends on its sign but not on its digit count. A new value is taken only
// once the last is through: the BCD conversion is bit-serial and there is a single character output register.
// busy stays high until the final character is on its way out.
module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_strobe,
    output logic [6:0]                    o_ascii_char,
    output logic                          o_last_char
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Controller
    sida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // Datapath
    sida_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_strobe     (o_strobe),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for signed_int_to_decimal_ascii: directed table, then random values.
// Depends on sida_pkg and the RTL of the converter; predicts the decimal text of each value.
module tb
    import sida_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W          = DEFAULT_VALUE_WIDTH;
    localparam int DIR_COUNT  = 20;
    localparam int RAND_COUNT = 460;
    localparam int MAX_PRINTS = 20;

    // One character of expected text
    typedef struct packed {
        logic [6:0] code;
        logic       final_char;
    } t_text_char;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [W-1:0]   i_value;
    logic                  o_strobe;
    logic [6:0]            o_ascii_char;
    logic                  o_last_char;

    t_text_char expected_chars[$];
    int         mismatches;
    int         numbers_sent;
    int         chars_seen;
    int         negatives_sent;

    // Directed table: empty text means the row is checked against the predictor
    logic signed [W-1:0] dir_values [DIR_COUNT] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
        -32'sd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sd999999999,
        32'sd1000000000, -32'sd1000000000, 32'sd1234567890, 32'sh5555_5555,
        32'shAAAA_AAAA, 32'sd4096, -32'sd7
    };
    string dir_text [DIR_COUNT] = '{
        "0", "1", "-1", "9", "10", "-10", "", "",
        "", "2147483647", "-2147483648", "-2147483647", "",
        "1000000000", "-1000000000", "", "",
        "", "", "-7"
    };

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_ascii_char(o_ascii_char),
        .o_last_char (o_last_char)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Expected characters typed in directly
    function automatic void queue_literal_text(input string s);
        t_text_char ch;
        for (int i = 0; i < s.len(); i++) begin
            ch.code       = 7'(s[i]);
            ch.final_char = (i == s.len() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // Decimal text of a signed value: optional minus, then magnitude digits, MSD first
    function automatic void queue_decimal_text(input logic signed [W-1:0] v);
        logic [W-1:0] mag;
        logic [3:0]   digit_buf[$];
        t_text_char   ch;
        // magnitude held unsigned so the most negative value does not overflow
        mag = v[W-1] ? (~v + 1'b1) : v;
        if (v[W-1]) begin
            ch.code       = CHAR_MINUS;
            ch.final_char = 1'b0;
            expected_chars.push_back(ch);
        end
        do begin
            digit_buf.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        foreach (digit_buf[k]) begin
            ch.code       = CHAR_ZERO + 7'(digit_buf[k]);
            ch.final_char = (k == digit_buf.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // Random value, biased towards every digit count and the extremes
    function automatic logic signed [W-1:0] random_value();
        logic signed [W-1:0] v;
        int                  p10;
        int                  exp10;
        case ($urandom_range(7))
            3: v = $urandom_range(200) - 100;
            4: begin
                exp10 = $urandom_range(9);
                p10   = 1;
                for (int i = 0; i < exp10; i++) p10 = p10 * 10;
                v = p10 + $urandom_range(2) - 1;
                if ($urandom_range(1)) v = -v;
            end
            5: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1)) v = -v;
            end
            6: begin
                case ($urandom_range(4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh8000_0001;
                    2: v = 32'sh7FFF_FFFF;
                    3: v = 32'sh7FFF_FFFE;
                    default: v = '0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one value; expectations queued at the edge that accepts the transaction
    task automatic send_number(input logic signed [W-1:0] v, input string text,
                               input bit idle_on);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < 12) gap += $urandom_range(1, 24);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
                i_value <= $urandom;
                @(posedge i_clk);
            end
        end
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        if (text.len() > 0) queue_literal_text(text);
        else queue_decimal_text(v);
        numbers_sent++;
        if (v[W-1]) negatives_sent++;
    endtask

    // Character checker: each strobe is compared against the oldest expectation
    always @(posedge i_clk) begin : char_check
        t_text_char want;
        if (i_rst_n && o_strobe) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d last=%0b",
                                          o_ascii_char, o_last_char));
            end else begin
                want = expected_chars.pop_front();
                if (o_ascii_char !== want.code)
                    report_mismatch($sformatf("ascii_char got %0d want %0d",
                                              o_ascii_char, want.code));
                if (o_last_char !== want.final_char)
                    report_mismatch($sformatf("last_char got %0b want %0b (char %0d)",
                                              o_last_char, want.final_char, want.code));
            end
        end
    end

    // Stimulus and end of run
    initial begin
        mismatches     = 0;
        numbers_sent   = 0;
        chars_seen     = 0;
        negatives_sent = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int n = 0; n < DIR_COUNT; n++) begin
            send_number(dir_values[n], dir_text[n], 1'b1);
        end

        // random values; a stretch in the middle runs back to back
        for (int n = 0; n < RAND_COUNT; n++) begin
            send_number(random_value(), "", !(n >= 200 && n < 320));
        end
        start <= 1'b0;

        // drain, then allow for one full conversion of slack
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Converted %0d numbers (%0d negative), %0d characters checked, %0d mismatches",
                 numbers_sent, negatives_sent, chars_seen, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sida_pkg.sv
rtl/sida_ctrl.sv
rtl/sida_dp.sv
rtl/signed_int_to_decimal_ascii.sv
dv/tb.sv
